>>> hw/rtl/att_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// att_pkg
// Widths, lane types and tables shared by the tilt angle pipeline.
// ----------------------------------------------------------------------------
package att_pkg;

    localparam int SAMPLE_BITS     = 14;
    localparam int GUARD_BITS      = 12;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int CORDIC_STAGES   = 16;
    localparam int ACC_FRAC        = 16;

    localparam int SQ_W     = 2 * SAMPLE_BITS;
    localparam int RAD_W    = SQ_W + 2 * GUARD_BITS;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 4;
    localparam int VEC_W    = SAMPLE_BITS + GUARD_BITS + 4;
    localparam int ACC_W    = 26;
    localparam int PITCH_W  = ANGLE_FRAC_BITS + 9;
    localparam int ROLL_W   = ANGLE_FRAC_BITS + 8;
    localparam int RND_SH   = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int PITCH_LIM = 180 * (2 ** ANGLE_FRAC_BITS);
    localparam int ROLL_LIM  = 90 * (2 ** ANGLE_FRAC_BITS);

    localparam logic signed [ACC_W-1:0] DEG180 = ACC_W'(180 * 65536);

    typedef enum logic [2:0] {
        MODE_DIRECT = 3'd0,
        MODE_ZERO   = 3'd1,
        MODE_PI     = 3'd2,
        MODE_ADD180 = 3'd3,
        MODE_SUB180 = 3'd4
    } mode_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [ACC_W-1:0] acc;
        mode_t                   mode;
    } lane_t;

    typedef struct packed {
        lane_t                   pitch;
        logic signed [VEC_W-1:0] roll_y;
        mode_t                   roll_mode;
    } side_t;

    typedef struct packed {
        logic [SQ_W-1:0]   sq;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
        side_t             side;
    } sqrt_t;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic logic signed [ACC_W-1:0] atan_val(input int i);
        logic signed [ACC_W-1:0] v;
        unique case (i)
            0:  v = ACC_W'(2949120);
            1:  v = ACC_W'(1740967);
            2:  v = ACC_W'(919879);
            3:  v = ACC_W'(466945);
            4:  v = ACC_W'(234379);
            5:  v = ACC_W'(117304);
            6:  v = ACC_W'(58666);
            7:  v = ACC_W'(29335);
            8:  v = ACC_W'(14668);
            9:  v = ACC_W'(7334);
            10: v = ACC_W'(3667);
            11: v = ACC_W'(1833);
            12: v = ACC_W'(917);
            13: v = ACC_W'(458);
            14: v = ACC_W'(229);
            15: v = ACC_W'(115);
            16: v = ACC_W'(57);
            17: v = ACC_W'(29);
            18: v = ACC_W'(14);
            19: v = ACC_W'(7);
            20: v = ACC_W'(4);
            21: v = ACC_W'(2);
            22: v = ACC_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // two radicand bits at digit k; radicand is sq scaled by the guard bits
    function automatic logic [1:0] pair_bits(input logic [SQ_W-1:0] sq, input int k);
        logic [RAD_W-1:0] n;
        n = {sq, {(2 * GUARD_BITS){1'b0}}};
        return n[2*k +: 2];
    endfunction

    // round half up to the output unit, then clamp to +-limit
    function automatic logic signed [ACC_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] v,
        input logic signed [ACC_W-1:0] limit
    );
        logic signed [ACC_W-1:0] r;
        r = (v + ACC_W'(2 ** (RND_SH - 1))) >>> RND_SH;
        if (r > limit)
        begin
            r = limit;
        end
        else if (r < -limit)
        begin
            r = -limit;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/att_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// att_if
// Valid/ready channels for sample triples and angle results.
// ----------------------------------------------------------------------------
interface att_in_if;
    logic valid;
    logic ready;
    logic signed [att_pkg::SAMPLE_BITS-1:0] accel_x;
    logic signed [att_pkg::SAMPLE_BITS-1:0] accel_y;
    logic signed [att_pkg::SAMPLE_BITS-1:0] accel_z;
    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface att_out_if;
    logic valid;
    logic ready;
    logic signed [att_pkg::PITCH_W-1:0] pitch_angle;
    logic signed [att_pkg::ROLL_W-1:0]  roll_angle;
    modport source (output valid, pitch_angle, roll_angle, input ready);
    modport sink (input valid, pitch_angle, roll_angle, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/att_sqrt_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// att_sqrt_pipe
// Digit-by-digit integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module att_sqrt_pipe (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  att_pkg::sqrt_t     in_data,
    output logic               out_valid,
    output att_pkg::sqrt_t     out_data
);

    localparam int N = att_pkg::ROOT_W;
    localparam int RW = att_pkg::REM_W;

    logic           valid_reg [1:N];
    att_pkg::sqrt_t data_reg  [1:N];

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic           stage_valid;
        att_pkg::sqrt_t cur;
        att_pkg::sqrt_t data_next;
        logic [RW-1:0]  shifted;
        logic [RW-1:0]  trial;

        if (s == 0)
        begin : g_head
            assign stage_valid = in_valid;
            assign cur         = in_data;
        end
        else
        begin : g_body
            assign stage_valid = valid_reg[s];
            assign cur         = data_reg[s];
        end

        always_comb
        begin
            data_next = cur;
            shifted   = {cur.rem[RW-3:0], att_pkg::pair_bits(cur.sq, N - 1 - s)};
            trial     = RW'({cur.root, 2'b01});
            if (shifted >= trial)
            begin
                data_next.rem  = shifted - trial;
                data_next.root = {cur.root[N-2:0], 1'b1};
            end
            else
            begin
                data_next.rem  = shifted;
                data_next.root = {cur.root[N-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s+1] <= stage_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                data_reg[s+1] <= data_next;
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign out_data  = data_reg[N];

endmodule
`default_nettype wire

>>> hw/rtl/att_cordic_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// att_cordic_pipe
// Vectoring CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module att_cordic_pipe (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  att_pkg::lane_t     in_lane,
    output logic               out_valid,
    output att_pkg::lane_t     out_lane
);

    localparam int N = att_pkg::CORDIC_STAGES;

    logic           valid_reg [1:N];
    att_pkg::lane_t lane_reg  [1:N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic           stage_valid;
        att_pkg::lane_t cur;
        att_pkg::lane_t lane_next;

        if (i == 0)
        begin : g_head
            assign stage_valid = in_valid;
            assign cur         = in_lane;
        end
        else
        begin : g_body
            assign stage_valid = valid_reg[i];
            assign cur         = lane_reg[i];
        end

        always_comb
        begin
            lane_next = cur;
            // rotate toward the x axis
            if (!cur.vy[att_pkg::VEC_W-1])
            begin
                lane_next.vx  = cur.vx + (cur.vy >>> i);
                lane_next.vy  = cur.vy - (cur.vx >>> i);
                lane_next.acc = cur.acc + att_pkg::atan_val(i);
            end
            else
            begin
                lane_next.vx  = cur.vx - (cur.vy >>> i);
                lane_next.vy  = cur.vy + (cur.vx >>> i);
                lane_next.acc = cur.acc - att_pkg::atan_val(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i+1] <= stage_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lane_reg[i+1] <= lane_next;
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign out_lane  = lane_reg[N];

endmodule
`default_nettype wire

>>> hw/rtl/accel_tilt_angles_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accel_tilt_angles_top
// Pitch and roll in 1/64 degree from one accelerometer sample triple.
// ----------------------------------------------------------------------------
//  port        dir  payload
//  sample_in   in   accel_x, accel_y, accel_z (signed 14)
//  angle_out   out  pitch_angle (signed 15), roll_angle (signed 14)
//
//  One request per cycle while the output is not stalled; the stages are the
//  squares, a sqrt stage per root bit, a CORDIC stage per rotation, round.
//  The whole pipeline advances together whenever the output register is
//  empty or being taken; a stall holds every stage in place.
//  Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module accel_tilt_angles_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    att_in_if.sink     sample_in,
    att_out_if.source  angle_out
);

    localparam int SB = att_pkg::SAMPLE_BITS;
    localparam int GB = att_pkg::GUARD_BITS;
    localparam int VW = att_pkg::VEC_W;
    localparam int QW = att_pkg::SQ_W;
    localparam int AW = att_pkg::ACC_W;

    logic en;
    logic out_valid_reg;
    logic signed [att_pkg::PITCH_W-1:0] pitch_reg, pitch_next;
    logic signed [att_pkg::ROLL_W-1:0]  roll_reg, roll_next;

    assign en              = !out_valid_reg || angle_out.ready;
    assign sample_in.ready = en;

    // front stage: squares and quadrant setup
    logic signed [QW-1:0] y_ext, z_ext, yy, zz;
    logic signed [VW-1:0] xs, ys, zs;
    att_pkg::sqrt_t front_next, front_reg;
    logic front_valid_reg;

    always_comb
    begin
        y_ext = QW'(sample_in.accel_y);
        z_ext = QW'(sample_in.accel_z);
        yy    = y_ext * y_ext;
        zz    = z_ext * z_ext;
        xs    = {{(VW-SB-GB){sample_in.accel_x[SB-1]}}, sample_in.accel_x, {GB{1'b0}}};
        ys    = {{(VW-SB-GB){sample_in.accel_y[SB-1]}}, sample_in.accel_y, {GB{1'b0}}};
        zs    = {{(VW-SB-GB){sample_in.accel_z[SB-1]}}, sample_in.accel_z, {GB{1'b0}}};

        front_next            = '0;
        front_next.sq         = QW'(yy + zz);
        front_next.side.roll_y = xs;
        front_next.side.roll_mode = (sample_in.accel_x == '0) ? att_pkg::MODE_ZERO
                                                              : att_pkg::MODE_DIRECT;
        front_next.side.pitch.acc = '0;
        if (sample_in.accel_y == '0)
        begin
            front_next.side.pitch.vx   = zs;
            front_next.side.pitch.vy   = ys;
            front_next.side.pitch.mode = sample_in.accel_z[SB-1] ? att_pkg::MODE_PI
                                                                 : att_pkg::MODE_ZERO;
        end
        else if (sample_in.accel_z[SB-1])
        begin
            // turn into the right half plane
            front_next.side.pitch.vx   = -zs;
            front_next.side.pitch.vy   = -ys;
            front_next.side.pitch.mode = sample_in.accel_y[SB-1] ? att_pkg::MODE_SUB180
                                                                 : att_pkg::MODE_ADD180;
        end
        else
        begin
            front_next.side.pitch.vx   = zs;
            front_next.side.pitch.vy   = ys;
            front_next.side.pitch.mode = att_pkg::MODE_DIRECT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            front_valid_reg <= sample_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_reg <= front_next;
        end
    end

    logic           sq_valid;
    att_pkg::sqrt_t sq_data;

    att_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid_reg),
        .in_data   (front_reg),
        .out_valid (sq_valid),
        .out_data  (sq_data)
    );

    att_pkg::lane_t roll_in, pitch_lane, roll_lane;
    logic pitch_valid, roll_valid;

    always_comb
    begin
        roll_in.vx   = VW'(sq_data.root);
        roll_in.vy   = sq_data.side.roll_y;
        roll_in.acc  = '0;
        roll_in.mode = sq_data.side.roll_mode;
    end

    att_cordic_pipe u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_lane   (sq_data.side.pitch),
        .out_valid (pitch_valid),
        .out_lane  (pitch_lane)
    );

    att_cordic_pipe u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_lane   (roll_in),
        .out_valid (roll_valid),
        .out_lane  (roll_lane)
    );

    // back stage: quadrant fix-up, rounding, clamp
    logic signed [AW-1:0] pitch_ang, roll_ang, pitch_r, roll_r;

    always_comb
    begin
        unique case (pitch_lane.mode)
            att_pkg::MODE_ZERO:   pitch_ang = '0;
            att_pkg::MODE_PI:     pitch_ang = att_pkg::DEG180;
            att_pkg::MODE_ADD180: pitch_ang = pitch_lane.acc + att_pkg::DEG180;
            att_pkg::MODE_SUB180: pitch_ang = pitch_lane.acc - att_pkg::DEG180;
            default:              pitch_ang = pitch_lane.acc;
        endcase
        roll_ang = (roll_lane.mode == att_pkg::MODE_ZERO) ? '0 : roll_lane.acc;
        pitch_r  = att_pkg::round_sat(-pitch_ang, AW'(att_pkg::PITCH_LIM));
        roll_r   = att_pkg::round_sat(roll_ang, AW'(att_pkg::ROLL_LIM));
        pitch_next = pitch_r[att_pkg::PITCH_W-1:0];
        roll_next  = roll_r[att_pkg::ROLL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= pitch_valid && roll_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_reg <= pitch_next;
            roll_reg  <= roll_next;
        end
    end

    assign angle_out.valid       = out_valid_reg;
    assign angle_out.pitch_angle = pitch_reg;
    assign angle_out.roll_angle  = roll_reg;

endmodule
`default_nettype wire
